@@ rtl/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constant tables for the ADSR envelope amplifier
// Op codes, register indexes, envelope modes, sequencer states and the
// per-setting cube and sustain tables.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam logic [1:0] OP_TRIGGER  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_SAMPLE   = 2'd2;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_INVERT  = 3'd4;
  localparam logic [2:0] REG_TSTEP   = 3'd5;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  // 0.008 in Q0.20
  localparam int KNEE = 8389;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ATTACK  = 3'd1,
    MODE_DECAY   = 3'd2,
    MODE_SUSTAIN = 3'd3,
    MODE_RELEASE = 3'd4
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TR1, ST_TR2, ST_TR3, ST_TR4, ST_TR5, ST_TR6, ST_TR7,
    ST_BR, ST_RD1, ST_RD2, ST_LP1, ST_LP2, ST_SC1, ST_SC2,
    ST_OUT1, ST_OUT2, ST_OUT3, ST_OUT4, ST_PUT
  } state_t;

  typedef logic [20:0] cube_tab_t [256];
  typedef logic [15:0] sus_tab_t [256];

  // cube of (base / 2550000) in Q1.20, truncated at each step
  function automatic logic [20:0] cube_q20(logic [63:0] base);
    logic [63:0] u;
    logic [63:0] c;
    u = (base << 20) / 64'd2550000;
    c = (((u * u) >> 20) * u) >> 20;
    return c[20:0];
  endfunction

  function automatic cube_tab_t build_cube(logic [63:0] top);
    cube_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = cube_q20(top - 64'd10000 * 64'(i));
    end
    return t;
  endfunction

  function automatic sus_tab_t build_sus();
    sus_tab_t t;
    logic [31:0] v;
    for (int i = 0; i < 256; i++) begin
      v = (32'(i) * 32'd32768 + 32'd127) / 32'd255;
      t[i] = v[15:0];
    end
    return t;
  endfunction

  localparam cube_tab_t ATK_CUBE  = build_cube(64'd2550255);
  localparam cube_tab_t FALL_CUBE = build_cube(64'd3060255);
  localparam sus_tab_t  SUS_LVL   = build_sus();

endpackage

@@ rtl/adsr_mul.sv @@
// ----------------------------------------------------------------------------
// adsr_mul: shared signed multiplier
// One registered 35 x 25 signed product, reused by the sequencer steps that multiply.
// ----------------------------------------------------------------------------
module adsr_mul (
  input  logic               clk,
  input  logic signed [34:0] a,
  input  logic signed [24:0] b,
  output logic signed [59:0] p
);

  always_ff @(posedge clk) begin
    p <= 60'(a * b);
  end

endmodule

@@ rtl/adsr_curve_rom.sv @@
// ----------------------------------------------------------------------------
// adsr_curve_rom: envelope curve table with registered read
// Attack curve (i/D)^2 or decay curve 1 - fourth root, built at elaboration.
// ----------------------------------------------------------------------------
module adsr_curve_rom import adsr_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter bit DECAY = 1'b0
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [15:0]              q
);

  localparam logic [63:0] DD  = 64'(DEPTH) * 64'(DEPTH);
  localparam logic [63:0] OFS = ((64'd1 << 60) / 64'd100000) * 64'd91;

  typedef logic [15:0] rom_t [DEPTH];

  function automatic logic [63:0] root2(logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = xin;
    r  = '0;
    bt = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic rom_t build();
    rom_t t;
    logic [63:0] i;
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] v;
    for (int n = 0; n < DEPTH; n++) begin
      i = 64'(n);
      if (DECAY) begin
        x = (((i << 48) / 64'(DEPTH)) << 12) + OFS;
        r = root2(root2(x));
        v = (r >= 64'd32768) ? 64'd0 : 64'd32768 - r;
      end else begin
        v = (i * i * 64'd32768 + DD / 2) / DD;
      end
      t[n] = v[15:0];
    end
    return t;
  endfunction

  localparam rom_t TAB = build();

  always_ff @(posedge clk) begin
    q <= TAB[addr];
  end

endmodule

@@ rtl/adsr_envelope_vca_core.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_vca_core: ADSR envelope amplifier
// Sequencer around one shared multiplier and two curve tables. Triggers
// derive the phase steps, samples walk the envelope and scale the signal.
// ----------------------------------------------------------------------------
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_stall, op, note_level,    | beat in
//          | sample_in                              |
//  out     | out_valid, out_stall, sample_out,      | beat out
//          | envelope_phase                         |
//  cfg     | cfg_we, cfg_index, cfg_data            | write only
//
// A trigger beat occupies the sequencer for three step products (two
// multiplies each on the shared multiplier). A sample beat in decay or
// release takes two table reads and five multiplies; in attack it has no
// scaling pass, and when the envelope skips interpolation it goes straight
// to the output pass. Each then hands the result to the output register. A
// note-off beat completes in its accept cycle.
// in_stall is high whenever the sequencer is busy. The output register frees
// the sequencer: the next beat is taken while a result waits on out_stall;
// a finished sample only waits when the output register is still full.
// rst is synchronous; it clears the envelope, steps and settings to their
// reset values. The curve tables are constants and need no fill.
// ----------------------------------------------------------------------------
module adsr_envelope_vca_core import adsr_pkg::*; #(
  parameter int CURVE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [7:0]         note_level,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic [2:0]         envelope_phase,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int AW = $clog2(CURVE_DEPTH);
  localparam int PW = AW + 16;
  localparam logic [59:0] PHASE_CAP  = 60'(CURVE_DEPTH) * 60'd65536 - 60'd1;
  localparam logic [PW-1:0] LAST_PHASE = PW'(CURVE_DEPTH - 1) << 16;
  localparam logic [AW-1:0] LAST_IDX   = AW'(CURVE_DEPTH - 1);
  localparam logic [24:0] ATK_SCALE = 25'(400 * CURVE_DEPTH);
  localparam logic [24:0] TWO_D     = 25'(2 * CURVE_DEPTH);

  // settings
  logic [7:0]  attack_setting, decay_setting, sustain_setting, release_setting;
  logic        invert_output;
  logic [23:0] time_step;

  // envelope state
  state_t         state, state_next;
  mode_t          env_mode, env_mode_next;
  logic [PW-1:0]  table_phase, table_phase_next;
  logic [15:0]    held_amp, held_amp_next;
  logic [7:0]     gain_level, gain_level_next;
  logic [PW-1:0]  attack_step, attack_step_next;
  logic [PW-1:0]  decay_step, decay_step_next;
  logic [PW-1:0]  release_step, release_step_next;

  // working registers
  logic signed [15:0] sample_reg, sample_reg_next;
  logic [15:0]        sus_amp, sus_amp_next;
  logic [15:0]        amp, amp_next;
  logic [15:0]        lerp_a, lerp_a_next;
  logic [15:0]        lerp_b, lerp_b_next;
  logic [31:0]        scratch, scratch_next;
  logic signed [17:0] m_val, m_val_next;
  logic signed [15:0] res, res_next;

  logic               out_valid_next;
  logic signed [15:0] sample_out_next;
  logic [2:0]         envelope_phase_next;

  // shared multiplier and tables
  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [59:0] prod;
  logic [AW-1:0]      rom_addr;
  logic [15:0]        atk_q, dec_q, rom_q;

  logic [AW-1:0] idx;
  logic [AW-1:0] idx_up;
  logic          idx_last;
  logic [15:0]   frac;
  logic          past;
  logic [33:0]   kraw, ksat;
  logic [32:0]   lerp_sum;
  logic [15:0]   lerp_v;
  logic signed [51:0] r_wide;
  logic signed [17:0] m_sel;

  adsr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  adsr_curve_rom #(.DEPTH(CURVE_DEPTH), .DECAY(1'b0)) u_atk_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (atk_q)
  );

  adsr_curve_rom #(.DEPTH(CURVE_DEPTH), .DECAY(1'b1)) u_dec_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (dec_q)
  );

  // clamp a wide phase or step value to the top of the table
  function automatic logic [PW-1:0] cap_ph(logic [59:0] v);
    return (v > PHASE_CAP) ? PHASE_CAP[PW-1:0] : v[PW-1:0];
  endfunction

  assign idx      = table_phase[PW-1:16];
  assign frac     = table_phase[15:0];
  assign idx_last = (idx == LAST_IDX);
  assign idx_up   = idx_last ? idx : idx + AW'(1);
  assign past     = (table_phase > LAST_PHASE);
  assign rom_q    = (env_mode == MODE_ATTACK) ? atk_q : dec_q;
  assign rom_addr = (state == ST_RD1) ? idx_up : idx;

  // fall-curve knee: drop 0.008 and floor at zero
  assign kraw = prod[33:0];
  assign ksat = (kraw > 34'(KNEE)) ? kraw - 34'(KNEE) : '0;

  assign lerp_sum = {1'b0, scratch} + {1'b0, prod[31:0]};
  assign lerp_v   = lerp_sum[31:16];
  assign r_wide   = prod[59:8];
  assign m_sel    = invert_output ? 18'sd32768 - m_val : m_val;

  assign in_stall = (state != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_setting  <= '0;
      decay_setting   <= '0;
      sustain_setting <= 8'd255;
      release_setting <= '0;
      invert_output   <= 1'b0;
      time_step       <= 24'd380;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  attack_setting  <= cfg_data[7:0];
        REG_DECAY:   decay_setting   <= cfg_data[7:0];
        REG_SUSTAIN: sustain_setting <= cfg_data[7:0];
        REG_RELEASE: release_setting <= cfg_data[7:0];
        REG_INVERT:  invert_output   <= cfg_data[0];
        REG_TSTEP:   time_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      env_mode     <= MODE_OFF;
      table_phase  <= '0;
      held_amp     <= '0;
      gain_level   <= '0;
      attack_step  <= '0;
      decay_step   <= '0;
      release_step <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      env_mode     <= env_mode_next;
      table_phase  <= table_phase_next;
      held_amp     <= held_amp_next;
      gain_level   <= gain_level_next;
      attack_step  <= attack_step_next;
      decay_step   <= decay_step_next;
      release_step <= release_step_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sample_reg     <= sample_reg_next;
    sus_amp        <= sus_amp_next;
    amp            <= amp_next;
    lerp_a         <= lerp_a_next;
    lerp_b         <= lerp_b_next;
    scratch        <= scratch_next;
    m_val          <= m_val_next;
    res            <= res_next;
    sample_out     <= sample_out_next;
    envelope_phase <= envelope_phase_next;
  end

  always_comb begin
    state_next          = state;
    env_mode_next       = env_mode;
    table_phase_next    = table_phase;
    held_amp_next       = held_amp;
    gain_level_next     = gain_level;
    attack_step_next    = attack_step;
    decay_step_next     = decay_step;
    release_step_next   = release_step;
    sample_reg_next     = sample_reg;
    sus_amp_next        = sus_amp;
    amp_next            = amp;
    lerp_a_next         = lerp_a;
    lerp_b_next         = lerp_b;
    scratch_next        = scratch;
    m_val_next          = m_val;
    res_next            = res;
    sample_out_next     = sample_out;
    envelope_phase_next = envelope_phase;
    // drop the output beat once it is taken
    out_valid_next      = out_valid & out_stall;
    mul_a               = '0;
    mul_b               = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_TRIGGER: begin
              gain_level_next  = note_level;
              table_phase_next = '0;
              if (attack_setting != 8'd0) begin
                env_mode_next = MODE_ATTACK;
                held_amp_next = '0;
              end else begin
                env_mode_next = MODE_DECAY;
                held_amp_next = ONE_Q15;
              end
              state_next = ST_TR1;
            end
            OP_NOTE_OFF: begin
              if (env_mode == MODE_ATTACK || env_mode == MODE_DECAY ||
                  env_mode == MODE_SUSTAIN) begin
                env_mode_next    = (release_setting != 8'd0) ? MODE_RELEASE : MODE_OFF;
                table_phase_next = '0;
              end
            end
            OP_SAMPLE: begin
              sample_reg_next = sample_in;
              sus_amp_next    = SUS_LVL[sustain_setting];
              state_next      = ST_BR;
            end
            default: ;
          endcase
        end
      end

      // attack step: cube * time_step, then * 400 * depth
      ST_TR1: begin
        mul_a      = {14'd0, ATK_CUBE[attack_setting]};
        mul_b      = {1'b0, time_step};
        state_next = ST_TR2;
      end
      ST_TR2: begin
        mul_a      = {2'b00, prod[44:12]};
        mul_b      = ATK_SCALE;
        state_next = ST_TR3;
      end
      ST_TR3: begin
        attack_step_next = (attack_setting != 8'd0) ? cap_ph({16'd0, prod[59:16]}) : '0;
        mul_a            = {14'd0, FALL_CUBE[decay_setting]};
        mul_b            = TWO_D;
        state_next       = ST_TR4;
      end
      ST_TR4: begin
        mul_a      = {1'b0, ksat};
        mul_b      = {1'b0, time_step};
        state_next = ST_TR5;
      end
      ST_TR5: begin
        decay_step_next = cap_ph({28'd0, prod[59:28]});
        mul_a           = {14'd0, FALL_CUBE[release_setting]};
        mul_b           = TWO_D;
        state_next      = ST_TR6;
      end
      ST_TR6: begin
        mul_a      = {1'b0, ksat};
        mul_b      = {1'b0, time_step};
        state_next = ST_TR7;
      end
      ST_TR7: begin
        release_step_next = cap_ph({28'd0, prod[59:28]});
        state_next        = ST_IDLE;
      end

      // pick the envelope path; table address for idx is presented here
      ST_BR: begin
        case (env_mode)
          MODE_ATTACK: begin
            if (past) begin
              held_amp_next    = ONE_Q15;
              amp_next         = ONE_Q15;
              env_mode_next    = MODE_DECAY;
              table_phase_next = '0;
              state_next       = ST_OUT1;
            end else begin
              state_next = ST_RD1;
            end
          end
          MODE_DECAY: begin
            if (past) begin
              held_amp_next    = sus_amp;
              amp_next         = sus_amp;
              if (sus_amp < ONE_Q15) env_mode_next = MODE_SUSTAIN;
              table_phase_next = cap_ph(60'(table_phase) + 60'(decay_step));
              state_next       = ST_OUT1;
            end else begin
              state_next = ST_RD1;
            end
          end
          MODE_SUSTAIN: begin
            held_amp_next = sus_amp;
            amp_next      = sus_amp;
            state_next    = ST_OUT1;
          end
          MODE_RELEASE: begin
            if (past) begin
              env_mode_next    = MODE_OFF;
              table_phase_next = '0;
              held_amp_next    = '0;
              amp_next         = '0;
              state_next       = ST_OUT1;
            end else begin
              state_next = ST_RD1;
            end
          end
          default: begin
            amp_next   = '0;
            state_next = ST_OUT1;
          end
        endcase
      end

      ST_RD1: begin
        lerp_a_next = rom_q;
        state_next  = ST_RD2;
      end
      ST_RD2: begin
        // past the last entry the far point carries zero weight
        lerp_b_next = idx_last ? 16'd0 : rom_q;
        mul_a       = {19'd0, lerp_a};
        mul_b       = {8'd0, 17'h10000 - {1'b0, frac}};
        state_next  = ST_LP1;
      end
      ST_LP1: begin
        scratch_next = prod[31:0];
        mul_a        = {19'd0, lerp_b};
        mul_b        = {9'd0, frac};
        state_next   = ST_LP2;
      end
      ST_LP2: begin
        if (env_mode == MODE_ATTACK) begin
          held_amp_next    = lerp_v;
          amp_next         = lerp_v;
          table_phase_next = cap_ph(60'(table_phase) + 60'(attack_step));
          state_next       = ST_OUT1;
        end else begin
          lerp_a_next = lerp_v;
          state_next  = ST_SC1;
        end
      end
      ST_SC1: begin
        mul_a = {19'd0, lerp_a};
        if (env_mode == MODE_DECAY) begin
          mul_b = {9'd0, ONE_Q15 - sus_amp};
        end else begin
          mul_b = {9'd0, held_amp};
        end
        state_next = ST_SC2;
      end
      ST_SC2: begin
        if (env_mode == MODE_DECAY) begin
          held_amp_next    = sus_amp + prod[30:15];
          amp_next         = sus_amp + prod[30:15];
          table_phase_next = cap_ph(60'(table_phase) + 60'(decay_step));
        end else begin
          amp_next         = prod[30:15];
          table_phase_next = cap_ph(60'(table_phase) + 60'(release_step));
        end
        state_next = ST_OUT1;
      end

      // amp * signal, then level * (m or 1 - m)
      ST_OUT1: begin
        mul_a      = {19'd0, amp};
        mul_b      = {{9{sample_reg[15]}}, sample_reg};
        state_next = ST_OUT2;
      end
      ST_OUT2: begin
        m_val_next = prod[32:15];
        state_next = ST_OUT3;
      end
      ST_OUT3: begin
        mul_a      = {{17{m_sel[17]}}, m_sel};
        mul_b      = {17'd0, gain_level};
        state_next = ST_OUT4;
      end
      ST_OUT4: begin
        if (r_wide > 52'sd32767) begin
          res_next = 16'sh7FFF;
        end else if (r_wide < -52'sd32768) begin
          res_next = 16'sh8000;
        end else begin
          res_next = r_wide[15:0];
        end
        state_next = ST_PUT;
      end
      ST_PUT: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          sample_out_next     = res;
          envelope_phase_next = env_mode;
          out_valid_next      = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ADSR envelope amplifier
// Feeds trigger, note-off and sample beats through the input channel, keeps a
// bit-exact model of the envelope alongside and checks every output beat,
// over several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import adsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint unsigned PH_CAP = (longint'(DEPTH) << 16) - 1;
  localparam longint unsigned PH_LAST = longint'(DEPTH - 1) << 16;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         lvl;
    logic signed [15:0] sig;
  } beat_t;

  typedef struct {
    logic signed [15:0] sample;
    logic [2:0]         phase;
  } result_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] op;
  logic [7:0] note_level;
  logic signed [15:0] sample_in, sample_out;
  logic [2:0] envelope_phase;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  adsr_envelope_vca_core #(.CURVE_DEPTH(DEPTH)) dut (.*);

  // beats waiting to go in, results the model says must come out
  beat_t   pending_beats[$];
  result_t want_results[$];
  int      err_count = 0;
  int      cyc = 0;
  bit      pressure_arm = 0;

  // shadow of the registers and the envelope state
  logic [7:0]  r_atk = 0, r_dec = 0, r_sus = 255, r_rel = 0;
  logic        r_inv = 0;
  logic [23:0] r_tstep = 380;
  mode_t           env = MODE_OFF;
  longint unsigned ph = 0, st_atk = 0, st_dec = 0, st_rel = 0;
  longint unsigned hold_amp = 0, gain = 0;
  longint unsigned atk_curve[DEPTH], dec_curve[DEPTH];

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cube(longint unsigned base);
    longint unsigned u = (base << 20) / 2550000;
    return (((u * u) >> 20) * u) >> 20;
  endfunction

  function automatic longint unsigned clamp_ph(longint unsigned v);
    return v > PH_CAP ? PH_CAP : v;
  endfunction

  function automatic longint unsigned fall_rate(logic [7:0] s);
    longint unsigned k = 2 * DEPTH * cube(3060255 - 10000 * longint'(s));
    k = k > KNEE ? k - KNEE : 0;
    return clamp_ph((k * r_tstep) >> 28);
  endfunction

  // interpolate one curve at the current phase; edge is the value past the end
  function automatic longint unsigned interp(bit use_atk, longint unsigned edge_v);
    longint unsigned k = ph >> 16, f = ph & 16'hFFFF, a, b;
    a = use_atk ? atk_curve[k] : dec_curve[k];
    b = (k + 1 >= DEPTH) ? edge_v : (use_atk ? atk_curve[k + 1] : dec_curve[k + 1]);
    return (a * (65536 - f) + b * f) >> 16;
  endfunction

  // advance the envelope by one accepted beat, queue a result for samples
  function automatic void envelope_beat(beat_t b);
    longint unsigned sus, amp, dv;
    longint m, r;
    bit past;
    result_t res;
    case (b.op)
      OP_TRIGGER: begin
        gain = b.lvl;
        if (r_atk > 0) begin
          st_atk = clamp_ph((((cube(2550255 - 10000 * longint'(r_atk)) * r_tstep) >> 12)
                             * 400 * DEPTH) >> 16);
          env = MODE_ATTACK;
          hold_amp = 0;
        end else begin
          st_atk = 0;
          env = MODE_DECAY;
          hold_amp = ONE_Q15;
        end
        st_dec = fall_rate(r_dec);
        st_rel = fall_rate(r_rel);
        ph = 0;
      end
      OP_NOTE_OFF: begin
        if (env inside {MODE_ATTACK, MODE_DECAY, MODE_SUSTAIN}) begin
          env = r_rel > 0 ? MODE_RELEASE : MODE_OFF;
          ph = 0;
        end
      end
      OP_SAMPLE: begin
        sus = (longint'(r_sus) * ONE_Q15 + 127) / 255;
        amp = 0;
        past = ph > PH_LAST;
        case (env)
          MODE_ATTACK: begin
            if (past) begin
              hold_amp = ONE_Q15;
              env = MODE_DECAY;
              ph = 0;
            end else begin
              hold_amp = interp(1, ONE_Q15);
              ph = clamp_ph(ph + st_atk);
            end
            amp = hold_amp;
          end
          MODE_DECAY: begin
            if (past) begin
              hold_amp = sus;
              if (sus < ONE_Q15) env = MODE_SUSTAIN;
            end else begin
              dv = interp(0, 0);
              hold_amp = sus + (((ONE_Q15 - sus) * dv) >> 15);
            end
            amp = hold_amp;
            ph = clamp_ph(ph + st_dec);
          end
          MODE_SUSTAIN: begin
            hold_amp = sus;
            amp = sus;
          end
          MODE_RELEASE: begin
            if (past) begin
              env = MODE_OFF;
              ph = 0;
              hold_amp = 0;
              amp = 0;
            end else begin
              dv = interp(0, 0);
              amp = (hold_amp * dv) >> 15;
              ph = clamp_ph(ph + st_rel);
            end
          end
          default: amp = 0;
        endcase
        m = (longint'(amp) * longint'(b.sig)) >>> 15;
        if (r_inv) r = (longint'(gain) * (longint'(ONE_Q15) - m)) >>> 8;
        else r = (longint'(gain) * m) >>> 8;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res.sample = r[15:0];
        res.phase = env;
        want_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // idle with a chance of roughly 6 in 100, except for a quiet window with no gaps
  function automatic bit idle_now();
    if (cyc > 3000 && cyc < 6000) return 0;
    return $urandom_range(99) < 6;
  endfunction

  // driver: drop the beat on acceptance, hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      op <= OP_SAMPLE;
      note_level <= 0;
      sample_in <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        envelope_beat(pending_beats.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && !idle_now()) begin
          in_valid <= 1;
          op <= pending_beats[0].op;
          note_level <= pending_beats[0].lvl;
          sample_in <= pending_beats[0].sig;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor: random stalls plus one long hold-off to fill the block up
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          $error("unexpected beat: sample_out %0d envelope_phase %0d",
                 sample_out, envelope_phase);
          err_count++;
        end else begin
          result_t w;
          w = want_results.pop_front();
          if (sample_out !== w.sample) begin
            $error("sample_out: expected %0d actual %0d", w.sample, sample_out);
            err_count++;
          end
          if (envelope_phase !== w.phase) begin
            $error("envelope_phase: expected %0d actual %0d", w.phase, envelope_phase);
            err_count++;
          end
        end
      end
      if (pressure_arm && !hold_done) begin
        hold_done <= 1;
        hold_left <= 300;
        out_stall <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  task automatic add_beat(logic [1:0] o, logic [7:0] l, logic signed [15:0] s);
    beat_t b;
    b.op = o;
    b.lvl = l;
    b.sig = s;
    pending_beats.push_back(b);
  endtask

  // wait until the block is drained, then let the trigger pipeline settle
  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid && want_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ATTACK:  r_atk = val[7:0];
      REG_DECAY:   r_dec = val[7:0];
      REG_SUSTAIN: r_sus = val[7:0];
      REG_RELEASE: r_rel = val[7:0];
      REG_INVERT:  r_inv = val[0];
      REG_TSTEP:   r_tstep = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_all(logic [7:0] a, logic [7:0] d, logic [7:0] s, logic [7:0] r,
                         logic inv, logic [23:0] ts);
    write_reg(REG_ATTACK, 24'(a));
    write_reg(REG_DECAY, 24'(d));
    write_reg(REG_SUSTAIN, 24'(s));
    write_reg(REG_RELEASE, 24'(r));
    write_reg(REG_INVERT, 24'(inv));
    write_reg(REG_TSTEP, ts);
  endtask

  // mostly note-shaped runs: trigger, a burst of samples, note off, tail
  task automatic random_notes(int n);
    int k = 0;
    while (k < n) begin
      int burst = $urandom_range(40, 2);
      add_beat(OP_TRIGGER, 8'($urandom), 16'($urandom));
      k++;
      repeat (burst) begin
        case ($urandom_range(99))
          0, 1:    add_beat(OP_UNUSED, 8'($urandom), 16'($urandom));
          2, 3:    add_beat(OP_NOTE_OFF, 8'($urandom), 16'($urandom));
          4:       add_beat(OP_TRIGGER, 8'($urandom), 16'($urandom));
          default: add_beat(OP_SAMPLE, 8'($urandom), 16'($urandom));
        endcase
        k++;
      end
      if ($urandom_range(3) != 0) begin
        add_beat(OP_NOTE_OFF, 8'($urandom), 16'($urandom));
        k++;
      end
      repeat ($urandom_range(15)) begin
        add_beat(OP_SAMPLE, 8'($urandom), 16'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    longint unsigned off;
    off = (64'd1 << 60) / 100000 * 91;
    for (int i = 0; i < DEPTH; i++) begin
      longint unsigned x, rt;
      atk_curve[i] = (longint'(i) * i * ONE_Q15 + DEPTH * DEPTH / 2) / (DEPTH * DEPTH);
      x = (((longint'(i) << 48) / DEPTH) << 12) + off;
      rt = isqrt(isqrt(x));
      dec_curve[i] = rt >= ONE_Q15 ? 0 : ONE_Q15 - rt;
    end
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // reset settings: no attack, sustain at full, so decay holds at 1.0
    add_beat(OP_SAMPLE, 8'hFF, 16'sh7FFF);
    add_beat(OP_TRIGGER, 8'hFF, 0);
    add_beat(OP_SAMPLE, 0, 16'sh7FFF);
    add_beat(OP_SAMPLE, 0, -16'sh8000);
    add_beat(OP_UNUSED, 8'hFF, 16'sh1234);
    add_beat(OP_NOTE_OFF, 0, 0);
    add_beat(OP_SAMPLE, 0, 0);
    add_beat(OP_NOTE_OFF, 0, 0);
    drain();

    // fast curves, inverted output, release active
    set_all(1, 1, 128, 1, 1, 24'hFFFFFF);
    add_beat(OP_TRIGGER, 8'hFF, 0);
    repeat (6) add_beat(OP_SAMPLE, 0, -16'sh8000);
    add_beat(OP_NOTE_OFF, 0, 0);
    repeat (4) add_beat(OP_SAMPLE, 0, 16'sh7FFF);
    add_beat(OP_NOTE_OFF, 0, 0);
    add_beat(OP_SAMPLE, 8'h80, 16'sh4000);
    add_beat(OP_TRIGGER, 0, 0);
    add_beat(OP_SAMPLE, 0, 16'sh7FFF);
    drain();
    write_reg(REG_UNUSED, 24'h5A5A5A);

    set_all(40, 60, 100, 50, 0, 24'd20000);
    pressure_arm = 1;
    random_notes(160);
    drain();

    set_all(255, 255, 0, 255, 1, 24'd0);
    random_notes(90);
    drain();

    set_all(0, 0, 255, 0, 0, 24'hFFFFFF);
    random_notes(120);
    drain();

    set_all(120, 20, 200, 10, 1, 24'd300000);
    random_notes(160);
    drain();

    set_all(5, 200, 30, 5, 0, 24'd60000);
    random_notes(160);
    drain();

    set_all(10, 10, 250, 100, 1, 24'd2000000);
    random_notes(160);
    drain();

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
